// ===== src/ssd_pkg.sv =====
// Shared types, constants and segment decode for the seven-segment scan display.
`default_nettype none

package ssd_pkg;

	localparam int unsigned NUM_W    = 16;
	localparam int unsigned DIGIT_W  = 4;
	localparam int unsigned SEG_W    = 7;
	localparam int unsigned SEL_W    = 4;
	localparam int unsigned HIGH_W   = 3;
	localparam int unsigned STORE_D  = 8;
	localparam int unsigned IDX_W    = 3;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic [DIGIT_W-1:0] BLANK_CODE = 4'd10;

	// Reciprocals for exact floor division of any 16-bit value.
	localparam logic [16:0] RECIP_10    = 17'd52429;  // shift 19
	localparam logic [16:0] RECIP_100   = 17'd83887;  // shift 23
	localparam logic [16:0] RECIP_1000  = 17'd67109;  // shift 26
	localparam logic [16:0] RECIP_10000 = 17'd107375; // shift 30

	typedef struct packed {
		logic [3:0][DIGIT_W-1:0] low;   // page 0, index 0 = ones digit
		logic [HIGH_W-1:0]       high;  // ten-thousands digit
	} ssd_digits_t;

	function automatic logic [SEG_W-1:0] seg_pattern(input logic [DIGIT_W-1:0] code);
		logic [SEG_W-1:0] seg;
		case (code)
			4'd0:    seg = 7'h3F;
			4'd1:    seg = 7'h06;
			4'd2:    seg = 7'h5B;
			4'd3:    seg = 7'h4F;
			4'd4:    seg = 7'h66;
			4'd5:    seg = 7'h6D;
			4'd6:    seg = 7'h7C;
			4'd7:    seg = 7'h07;
			4'd8:    seg = 7'h7F;
			4'd9:    seg = 7'h67;
			default: seg = 7'h00;
		endcase
		return seg;
	endfunction

endpackage

`default_nettype wire

// ===== src/seven_segment_scan_display.sv =====
// Top level: stream front end, digit store, scan and page timer, result register.
`default_nettype none

// Multiplexed seven-segment scan driver. Each input transaction is a load
// (tuser = 0, tdata = 16-bit number) or a scan tick (tuser = 1). A load writes
// the decimal digits into the store and produces no output; a tick produces one
// output transaction with the segment pattern and one-hot digit select of the
// current scan position, then advances the scan and the page timer. The block
// takes one transaction per clock while the output is not stalled; a tick
// passes through the input register, then the quotient register, then the
// result register, where its output becomes valid.
// All stages hold together while the output is stalled, so m_axis_tready sets
// the throughput. cfg_wr_en / cfg_wr_data load page_period (reset 1000): the
// shown page advances once the tick count exceeds it.

module seven_segment_scan_display
	import ssd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,  // [15:0] number
	input  wire logic [0:0]  s_axis_tuser,  // [0] opcode
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata,  // [6:0] segments, [10:7] digit_select
	input  wire logic        cfg_wr_en,
	input  wire logic [15:0] cfg_wr_data
);

	logic en;
	logic valid_s1, valid_s2;
	logic op_s1, op_s2;
	logic [NUM_W-1:0] number_s1;
	ssd_digits_t digits_s2;

	logic [DIGIT_W-1:0] store_q [STORE_D];
	logic two_pages_q;
	logic [1:0] scan_q;
	logic shown_page_q;
	logic [NUM_W-1:0] tick_cnt_q;
	logic [NUM_W-1:0] period_q;
	logic [SEG_W-1:0] seg_q;
	logic [SEL_W-1:0] sel_q;
	logic valid_out_q;

	// hold every stage while a result waits
	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = valid_out_q;
	assign m_axis_tdata  = {5'b0, sel_q, seg_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			op_s1    <= OP_LOAD;
			op_s2    <= OP_LOAD;
		end else if (en) begin
			valid_s1 <= s_axis_tvalid;
			valid_s2 <= valid_s1;
			op_s1    <= s_axis_tuser[0];
			op_s2    <= op_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			number_s1 <= s_axis_tdata;
		end
	end

	ssd_digit_split u_split (
		.clk       (clk),
		.en        (en),
		.number_s1 (number_s1),
		.digits_s2 (digits_s2)
	);

	logic do_load, do_tick;
	logic [IDX_W-1:0] rd_idx;
	logic [NUM_W-1:0] cnt_inc;
	logic page_switch;

	assign do_load     = en && valid_s2 && (op_s2 == OP_LOAD);
	assign do_tick     = en && valid_s2 && (op_s2 == OP_TICK);
	assign rd_idx      = {shown_page_q, scan_q};
	assign cnt_inc     = tick_cnt_q + NUM_W'(1);
	assign page_switch = cnt_inc > period_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < STORE_D; k++) begin
				store_q[k] <= '0;
			end
			two_pages_q <= 1'b0;
		end else if (do_load) begin
			for (int k = 0; k < 4; k++) begin
				store_q[k] <= digits_s2.low[k];
			end
			if (digits_s2.high != '0) begin
				store_q[4]  <= DIGIT_W'(digits_s2.high);
				store_q[5]  <= BLANK_CODE;
				store_q[6]  <= BLANK_CODE;
				store_q[7]  <= BLANK_CODE;
				two_pages_q <= 1'b1;
			end else begin
				two_pages_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q       <= '0;
			shown_page_q <= 1'b0;
			tick_cnt_q   <= '0;
		end else if (do_tick) begin
			scan_q <= scan_q + 2'd1;
			if (page_switch) begin
				// advance, wrapping to page 0 past the last page in use
				shown_page_q <= !shown_page_q && two_pages_q;
				tick_cnt_q   <= '0;
			end else begin
				tick_cnt_q <= cnt_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= NUM_W'(1000);
		end else if (cfg_wr_en) begin
			period_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out_q <= 1'b0;
		end else if (en) begin
			valid_out_q <= valid_s2 && (op_s2 == OP_TICK);
		end
	end

	always_ff @(posedge clk) begin
		if (do_tick) begin
			seg_q <= seg_pattern(store_q[rd_idx]);
			sel_q <= SEL_W'(4'b1000 >> scan_q);
		end
	end

endmodule

`default_nettype wire

// ===== src/ssd_digit_split.sv =====
// Decimal split of a 16-bit number: registered reciprocal quotients, then digit extraction.
`default_nettype none

module ssd_digit_split
	import ssd_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [NUM_W-1:0] number_s1,
	output ssd_digits_t           digits_s2
);

	logic [32:0] prod1, prod2, prod3, prod4;
	logic [NUM_W-1:0] num_s2;
	logic [12:0] q1_s2;
	logic [9:0]  q2_s2;
	logic [6:0]  q3_s2;
	logic [HIGH_W-1:0] q4_s2;

	assign prod1 = 33'(number_s1) * 33'(RECIP_10);
	assign prod2 = 33'(number_s1) * 33'(RECIP_100);
	assign prod3 = 33'(number_s1) * 33'(RECIP_1000);
	assign prod4 = 33'(number_s1) * 33'(RECIP_10000);

	always_ff @(posedge clk) begin
		if (en) begin
			num_s2 <= number_s1;
			q1_s2  <= prod1[19 +: 13];
			q2_s2  <= prod2[23 +: 10];
			q3_s2  <= prod3[26 +: 7];
			q4_s2  <= prod4[30 +: HIGH_W];
		end
	end

	logic [NUM_W-1:0] r0;
	logic [12:0]      r1;
	logic [9:0]       r2;
	logic [6:0]       r3;

	// digit k = q(k) - 10 * q(k+1)
	always_comb begin
		r0 = num_s2 - NUM_W'({q1_s2, 3'b000}) - NUM_W'({q1_s2, 1'b0});
		r1 = q1_s2 - 13'({q2_s2, 3'b000}) - 13'({q2_s2, 1'b0});
		r2 = q2_s2 - 10'({q3_s2, 3'b000}) - 10'({q3_s2, 1'b0});
		r3 = q3_s2 - 7'({q4_s2, 3'b000}) - 7'({q4_s2, 1'b0});
		digits_s2.low[0] = r0[DIGIT_W-1:0];
		// blank upper digits once the remaining quotient is zero
		digits_s2.low[1] = (q1_s2 == '0) ? BLANK_CODE : r1[DIGIT_W-1:0];
		digits_s2.low[2] = (q2_s2 == '0) ? BLANK_CODE : r2[DIGIT_W-1:0];
		digits_s2.low[3] = (q3_s2 == '0) ? BLANK_CODE : r3[DIGIT_W-1:0];
		digits_s2.high   = q4_s2;
	end

endmodule

`default_nettype wire
